// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a plain expression at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check a temporal property outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`endif
`endif

// ----- sv/slug_pkg.sv -----
package slug_pkg;

   localparam int MAX_OUT = 5;

   localparam logic [7:0] LEAD_C3   = 8'hC3;
   localparam logic [7:0] LEAD_C2   = 8'hC2;
   localparam logic [7:0] SEP_RESET = 8'd45;
   localparam logic [7:0] CASE_BIT  = 8'd32;

   // result of classifying one byte
   typedef struct packed {
      logic        emit;
      logic        consumed;
      logic [15:0] code;
   } proc_type;

   // results gathered for one word, plus the word-boundary flags
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] chars;
      logic [2:0]              cnt;
      logic                    text_seen;
      logic                    sep_pending;
   } acc_type;

   // one queue entry: all results caused by one input word
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] chars;
      logic [2:0]              cnt;
      logic                    bare;
      logic                    last;
   } bundle_type;

   function automatic logic [15:0] m1(logic [7:0] a);
      return {8'h00, a};
   endfunction

   function automatic logic [15:0] m2(logic [7:0] a, logic [7:0] b);
      return {b, a};
   endfunction

   // second byte after 0xC3
   function automatic logic [15:0] map_c3(logic [7:0] t);
      logic [15:0] r;
      unique case (t) inside
         8'h9f: r = m2("s", "s");
         8'h84, 8'ha4, 8'ha6, 8'h86: r = m2("a", "e");
         8'h96, 8'hb6: r = m2("o", "e");
         8'h9c, 8'hbc: r = m2("u", "e");
         8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha5,
         8'h80, 8'h81, 8'h82, 8'h83, 8'h85: r = m1("a");
         8'ha8, 8'ha9, 8'haa, 8'hab,
         8'h88, 8'h89, 8'h8a, 8'h8b: r = m1("e");
         8'hac, 8'had, 8'hae, 8'haf,
         8'h8c, 8'h8d, 8'h8e, 8'h8f: r = m1("i");
         8'hb0, 8'hb2, 8'hb3, 8'hb4, 8'hb5,
         8'h92, 8'h93, 8'h94, 8'h95: r = m1("o");
         8'hb9, 8'hba, 8'hbb, 8'h99, 8'h9a, 8'h9b: r = m1("u");
         8'h91, 8'hb1: r = m1("n");
         8'h87, 8'ha7: r = m1("c");
         8'h9e, 8'hbe: r = m1("p");
         8'hbf, 8'h9d, 8'hbd: r = m1("y");
         8'h97: r = m1("x");
         8'h90: r = m1("d");
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

   // second byte after 0xC2
   function automatic logic [15:0] map_c2(logic [7:0] t);
      logic [15:0] r;
      unique case (t) inside
         8'hb5: r = m1("u");
         8'ha7, 8'ha2: r = m1("c");
         8'ha5: r = m1("y");
         8'hae: r = m1("r");
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

   // single Latin-1 byte
   function automatic logic [15:0] map_latin1(logic [7:0] c);
      logic [15:0] r;
      unique case (c) inside
         8'd223: r = m2("s", "s");
         8'd196, 8'd198, 8'd228, 8'd230: r = m2("a", "e");
         8'd214, 8'd246: r = m2("o", "e");
         8'd220, 8'd252: r = m2("u", "e");
         8'd192, 8'd193, 8'd194, 8'd195, 8'd197,
         8'd224, 8'd225, 8'd226, 8'd227, 8'd229: r = m1("a");
         8'd200, 8'd201, 8'd202, 8'd203,
         8'd232, 8'd233, 8'd234, 8'd235: r = m1("e");
         8'd161, 8'd204, 8'd205, 8'd206, 8'd207,
         8'd236, 8'd237, 8'd238, 8'd239: r = m1("i");
         8'd210, 8'd211, 8'd212, 8'd213,
         8'd240, 8'd242, 8'd243, 8'd244, 8'd245: r = m1("o");
         8'd181, 8'd217, 8'd218, 8'd219,
         8'd249, 8'd250, 8'd251: r = m1("u");
         8'd209, 8'd241: r = m1("n");
         8'd162, 8'd169, 8'd199, 8'd231: r = m1("c");
         8'd222, 8'd254: r = m1("p");
         8'd165, 8'd221, 8'd253, 8'd255: r = m1("y");
         8'd215: r = m1("x");
         8'd174: r = m1("r");
         8'd208: r = m1("d");
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

   // classify byte c with optional lookahead t
   function automatic proc_type classify(logic [7:0] c, logic [7:0] t, logic has_t);
      proc_type    p;
      logic [15:0] pair;
      p      = '0;
      pair   = (c == LEAD_C3) ? map_c3(t) : map_c2(t);
      if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
         p.code = {8'h00, c};
      end else if (c >= "A" && c <= "Z") begin
         p.code = {8'h00, c | CASE_BIT};
      end else if (has_t && (c == LEAD_C3 || c == LEAD_C2) && pair != 16'h0000) begin
         p.code     = pair;
         p.consumed = 1'b1;
      end else begin
         p.code = map_latin1(c);
      end
      p.emit = (p.code != 16'h0000);
      return p;
   endfunction

   // append the characters of one classified byte, or note a word break
   function automatic acc_type apply(acc_type a, proc_type p, logic [7:0] sep);
      acc_type r;
      r = a;
      if (p.emit) begin
         if (r.sep_pending) begin
            r.chars[r.cnt] = sep;
            r.cnt          = r.cnt + 3'd1;
            r.sep_pending  = 1'b0;
         end
         r.chars[r.cnt] = p.code[7:0];
         r.cnt          = r.cnt + 3'd1;
         if (p.code[15:8] != 8'h00) begin
            r.chars[r.cnt] = p.code[15:8];
            r.cnt          = r.cnt + 3'd1;
         end
         r.text_seen = 1'b1;
      end else if (r.text_seen) begin
         r.sep_pending = 1'b1;
         r.text_seen   = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- sv/slug_front.sv -----
`include "assert_macros.svh"

module slug_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  q_full,
   output logic                  push,
   output slug_pkg::bundle_type  bundle
);

   logic [7:0] sep_char_ff;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       text_seen_ff, text_seen_in;
   logic       sep_pending_ff, sep_pending_in;
   logic       accept;

   slug_pkg::proc_type p_held, p_tail;
   slug_pkg::acc_type  acc0, acc1, acc2;
   logic [7:0]         hb_mid;
   logic               hv_mid;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // classify the held byte against the new one, then flush on end of string
   always_comb begin
      acc0             = '0;
      acc0.text_seen   = text_seen_ff;
      acc0.sep_pending = sep_pending_ff;
      p_held = slug_pkg::classify(held_byte_ff, req_tdata, 1'b1);
      acc1   = held_valid_ff ? slug_pkg::apply(acc0, p_held, sep_char_ff) : acc0;
      if (held_valid_ff && p_held.consumed) begin
         hv_mid = 1'b0;
         hb_mid = 8'h00;
      end else begin
         hv_mid = 1'b1;
         hb_mid = req_tdata;
      end
      p_tail = slug_pkg::classify(hb_mid, 8'h00, 1'b0);
      acc2   = (req_tlast && hv_mid) ? slug_pkg::apply(acc1, p_tail, sep_char_ff) : acc1;

      bundle.chars = acc2.chars;
      bundle.cnt   = acc2.cnt;
      bundle.bare  = 1'b0;
      bundle.last  = req_tlast;
      if (req_tlast && acc2.cnt == 3'd0) begin
         bundle.cnt  = 3'd1;
         bundle.bare = 1'b1;
      end
      push = accept && (acc2.cnt != 3'd0 || req_tlast);

      if (req_tlast) begin
         held_byte_in   = 8'h00;
         held_valid_in  = 1'b0;
         text_seen_in   = 1'b0;
         sep_pending_in = 1'b0;
      end else begin
         held_byte_in   = hb_mid;
         held_valid_in  = hv_mid;
         text_seen_in   = acc2.text_seen;
         sep_pending_in = acc2.sep_pending;
      end
   end

   // hold separator and lookahead state
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_char_ff    <= slug_pkg::SEP_RESET;
         held_byte_ff   <= 8'h00;
         held_valid_ff  <= 1'b0;
         text_seen_ff   <= 1'b0;
         sep_pending_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            sep_char_ff <= csr_wdata;
         end
         if (accept) begin
            held_byte_ff   <= held_byte_in;
            held_valid_ff  <= held_valid_in;
            text_seen_ff   <= text_seen_in;
            sep_pending_ff <= sep_pending_in;
         end
      end
   end

   `ASSERT_ALWAYS(a_front_cnt, clock, reset, !push || (bundle.cnt != 3'd0 && bundle.cnt <= 3'd5), "front: bad result count")
   `ASSERT_ALWAYS(a_front_bare, clock, reset, !bundle.bare || (bundle.last && bundle.cnt == 3'd1), "front: bare marker without end of string")
   `ASSERT_PROP(a_front_clear, clock, reset, (accept && req_tlast) |=> (!held_valid_ff && !sep_pending_ff), "front: state not cleared at end of string")

endmodule

// ----- sv/slug_queue.sv -----
`include "assert_macros.svh"

module slug_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  slug_pkg::bundle_type  din,
   input  logic                  pop,
   output slug_pkg::bundle_type  dout,
   output logic                  q_valid,
   output logic                  q_full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   slug_pkg::bundle_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign dout    = entry_ff[rd_ptr_ff];

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `ASSERT_ALWAYS(a_q_no_overflow, clock, reset, !(push && q_full), "queue: push while full")
   `ASSERT_ALWAYS(a_q_no_underflow, clock, reset, !(pop && !q_valid), "queue: pop while empty")
   `ASSERT_PROP(a_q_count, clock, reset, (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1), "queue: count did not drop")

endmodule

// ----- sv/slug_back.sv -----
`include "assert_macros.svh"

module slug_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  slug_pkg::bundle_type  dout,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   slug_pkg::bundle_type cur_ff;
   logic                 busy_ff;
   logic [2:0]           slot_ff;
   logic                 final_slot;

   assign final_slot = (slot_ff == cur_ff.cnt - 3'd1);
   assign pop        = q_valid && (!busy_ff || (rsp_tready && final_slot));

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = cur_ff.bare ? 8'h00 : cur_ff.chars[slot_ff];
   assign rsp_tuser  = {final_slot, !cur_ff.bare};
   assign rsp_tlast  = final_slot && cur_ff.last;

   // load the next bundle or step through the current one
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= 3'd0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         slot_ff <= 3'd0;
      end else if (busy_ff && rsp_tready) begin
         if (final_slot) begin
            busy_ff <= 1'b0;
         end else begin
            slot_ff <= slot_ff + 3'd1;
         end
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= dout;
      end
   end

   `ASSERT_ALWAYS(a_back_slot, clock, reset, !busy_ff || slot_ff < cur_ff.cnt, "back: slot past bundle end")

endmodule

// ----- sv/slug_transliterator_core.sv -----
// Slug transliterator: turns a byte string into a lower-case ASCII slug.
// Input channel req_*: one raw byte per word, req_tlast on the final byte.
// Output channel rsp_*: one character per word; rsp_tuser[0] says the byte is
// valid (0 on a bare end marker), rsp_tuser[1] marks the last word caused by
// an input word, rsp_tlast marks the final word of the whole string.
// csr_we/csr_wdata set the separator byte (hyphen after reset); write it only
// while the block is idle.
// A front stage classifies each byte against one byte of lookahead and packs
// up to five result characters into a bundle; a small queue hands bundles to
// a back stage that sends them one word per cycle while rsp_tready is high.
// The first word caused by an input is written to a queue entry and then
// loaded into the back-stage payload register before it is offered.
// Throughput: one input word per cycle while the queue has room; the output
// port sends one word per cycle while rsp_tready is high, one bundle after
// another. Inputs that yield nothing are not pushed into the queue.
// Reset clears the lookahead, word state, queue and output; no clearing pass.
// When rsp_tready is low the back stage holds its word, the queue fills, and
// then req_tready drops.
module slug_transliterator_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic [1:0] rsp_tuser,    // [0] char_valid, [1] run_end
   output logic       rsp_tlast
);

   slug_pkg::bundle_type push_bundle, head_bundle;
   logic push, pop, q_valid, q_full;

   slug_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .bundle     (push_bundle)
   );

   slug_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .din     (push_bundle),
      .pop     (pop),
      .dout    (head_bundle),
      .q_valid (q_valid),
      .q_full  (q_full)
   );

   slug_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .dout       (head_bundle),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/sv/slug_transliterator_core_tb.sv -----
`timescale 1ns / 1ps

module slug_transliterator_core_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int HOLD_CYCLES    = 60;
   localparam int PHASE_WORDS    = 48;

   // one expected output word
   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic       run_end;
      logic       str_end;
   } slug_char_type;

   // slug predictor plus the queue of characters still owed by the block
   class slug_scoreboard;
      logic [7:0]    sep;
      logic [7:0]    look_byte;
      bit            look_full;
      bit            word_open;
      bit            sep_owed;
      slug_char_type batch[$];
      slug_char_type want_q[$];
      int            errors;
      int            words_in;
      int            words_out;
      int            text_count;

      function new();
         sep       = slug_pkg::SEP_RESET;
         look_byte = 8'h00;
         look_full = 1'b0;
         word_open = 1'b0;
         sep_owed  = 1'b0;
      endfunction

      // second letter sits in the upper byte, zero when there is none
      static function logic [15:0] pair_c3(logic [7:0] t);
         case (t)
            8'h9f: return {"s", "s"};
            8'h84, 8'ha4, 8'ha6, 8'h86: return {"e", "a"};
            8'h96, 8'hb6: return {"e", "o"};
            8'h9c, 8'hbc: return {"e", "u"};
            8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha5,
            8'h80, 8'h81, 8'h82, 8'h83, 8'h85: return {8'h00, "a"};
            8'ha8, 8'ha9, 8'haa, 8'hab,
            8'h88, 8'h89, 8'h8a, 8'h8b: return {8'h00, "e"};
            8'hac, 8'had, 8'hae, 8'haf,
            8'h8c, 8'h8d, 8'h8e, 8'h8f: return {8'h00, "i"};
            8'hb0, 8'hb2, 8'hb3, 8'hb4, 8'hb5,
            8'h92, 8'h93, 8'h94, 8'h95: return {8'h00, "o"};
            8'hb9, 8'hba, 8'hbb, 8'h99, 8'h9a, 8'h9b: return {8'h00, "u"};
            8'h91, 8'hb1: return {8'h00, "n"};
            8'h87, 8'ha7: return {8'h00, "c"};
            8'h9e, 8'hbe: return {8'h00, "p"};
            8'hbf, 8'h9d, 8'hbd: return {8'h00, "y"};
            8'h97: return {8'h00, "x"};
            8'h90: return {8'h00, "d"};
            default: return 16'h0000;
         endcase
      endfunction

      static function logic [15:0] pair_c2(logic [7:0] t);
         case (t)
            8'hb5: return {8'h00, "u"};
            8'ha7, 8'ha2: return {8'h00, "c"};
            8'ha5: return {8'h00, "y"};
            8'hae: return {8'h00, "r"};
            default: return 16'h0000;
         endcase
      endfunction

      static function logic [15:0] latin1_fold(logic [7:0] c);
         case (c)
            8'd223: return {"s", "s"};
            8'd196, 8'd198, 8'd228, 8'd230: return {"e", "a"};
            8'd214, 8'd246: return {"e", "o"};
            8'd220, 8'd252: return {"e", "u"};
            8'd192, 8'd193, 8'd194, 8'd195, 8'd197,
            8'd224, 8'd225, 8'd226, 8'd227, 8'd229: return {8'h00, "a"};
            8'd200, 8'd201, 8'd202, 8'd203,
            8'd232, 8'd233, 8'd234, 8'd235: return {8'h00, "e"};
            8'd161, 8'd204, 8'd205, 8'd206, 8'd207,
            8'd236, 8'd237, 8'd238, 8'd239: return {8'h00, "i"};
            8'd210, 8'd211, 8'd212, 8'd213,
            8'd240, 8'd242, 8'd243, 8'd244, 8'd245: return {8'h00, "o"};
            8'd181, 8'd217, 8'd218, 8'd219,
            8'd249, 8'd250, 8'd251: return {8'h00, "u"};
            8'd209, 8'd241: return {8'h00, "n"};
            8'd162, 8'd169, 8'd199, 8'd231: return {8'h00, "c"};
            8'd222, 8'd254: return {8'h00, "p"};
            8'd165, 8'd221, 8'd253, 8'd255: return {8'h00, "y"};
            8'd215: return {8'h00, "x"};
            8'd174: return {8'h00, "r"};
            8'd208: return {8'h00, "d"};
            default: return 16'h0000;
         endcase
      endfunction

      function void push_char(logic [7:0] ch);
         slug_char_type w;
         w = '{ch: ch, valid: 1'b1, run_end: 1'b0, str_end: 1'b0};
         if (batch.size() < slug_pkg::MAX_OUT) batch.push_back(w);
      endfunction

      // emit the owed separator, then one or two letters
      function void append_code(logic [15:0] code);
         if (sep_owed) begin
            push_char(sep);
            sep_owed = 1'b0;
         end
         push_char(code[7:0]);
         if (code[15:8] != 8'h00) push_char(code[15:8]);
         word_open = 1'b1;
      endfunction

      // translate byte c with optional lookahead t; return 1 when t is used up
      function bit translate(logic [7:0] c, logic [7:0] t, bit has_t);
         logic [15:0] code;
         if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
            append_code({8'h00, c});
            return 1'b0;
         end
         if (c >= "A" && c <= "Z") begin
            append_code({8'h00, c | slug_pkg::CASE_BIT});
            return 1'b0;
         end
         if (has_t && (c == slug_pkg::LEAD_C3 || c == slug_pkg::LEAD_C2)) begin
            code = (c == slug_pkg::LEAD_C3) ? pair_c3(t) : pair_c2(t);
            if (code != 16'h0000) begin
               append_code(code);
               return 1'b1;
            end
         end
         code = latin1_fold(c);
         if (code != 16'h0000) begin
            append_code(code);
            return 1'b0;
         end
         // a word break owes one separator before the next letter
         if (word_open) begin
            sep_owed  = 1'b1;
            word_open = 1'b0;
         end
         return 1'b0;
      endfunction

      // predict the output words caused by one accepted input word
      function void note_word(logic [7:0] b, logic last);
         batch.delete();
         if (look_full) begin
            if (translate(look_byte, b, 1'b1)) begin
               look_full = 1'b0;
               look_byte = 8'h00;
            end else begin
               look_byte = b;
            end
         end else begin
            look_byte = b;
            look_full = 1'b1;
         end
         if (last) begin
            if (look_full) void'(translate(look_byte, 8'h00, 1'b0));
            look_full = 1'b0;
            look_byte = 8'h00;
            word_open = 1'b0;
            sep_owed  = 1'b0;
            // an empty ending still yields a bare end marker
            if (batch.size() == 0) batch.push_back('0);
            text_count++;
         end
         if (batch.size() > 0) begin
            batch[batch.size() - 1].run_end = 1'b1;
            batch[batch.size() - 1].str_end = last;
         end
         foreach (batch[i]) want_q.push_back(batch[i]);
         words_in++;
      endfunction

      // compare one output word with the oldest prediction
      function void check_word(logic [7:0] ch, logic valid, logic run_end, logic str_end);
         slug_char_type w;
         words_out++;
         if (want_q.size() == 0) begin
            $error("unexpected output word: out_char 8'h%02h", ch);
            errors++;
            return;
         end
         w = want_q.pop_front();
         if (ch !== w.ch) begin
            $error("out_char: expected 8'h%02h, got 8'h%02h", w.ch, ch);
            errors++;
         end
         if (valid !== w.valid) begin
            $error("char_valid: expected %0b, got %0b", w.valid, valid);
            errors++;
         end
         if (run_end !== w.run_end) begin
            $error("run_end: expected %0b, got %0b", w.run_end, run_end);
            errors++;
         end
         if (str_end !== w.str_end) begin
            $error("string_end: expected %0b, got %0b", w.str_end, str_end);
            errors++;
         end
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_we     = 1'b0;
   logic [7:0] csr_wdata  = 8'h00;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;    // [7:0] in_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;             // [7:0] out_char
   logic [1:0] rsp_tuser;             // [0] char_valid, [1] run_end
   logic       rsp_tlast;

   slug_scoreboard sb;
   bit             steady   = 1'b0;
   bit             hold_rsp = 1'b0;
   int             stalled_cycles = 0;
   int             sep_settings   = 1;
   logic [7:0]     text_q[$];

   slug_transliterator_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // record accepted words on both sides and guard against a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_word(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // receiver: random back-pressure, plus a long hold-off on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 13);
         end
      end
   end

   // offer one word, idling at random first, and wait until it is taken
   task automatic send_word(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait until every predicted word has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sep(input logic [7:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.sep = v;
      sep_settings++;
   endtask

   // build one random string: mostly words, some punctuation and noise
   function automatic void make_text();
      int n;
      int kind;
      text_q.delete();
      n = $urandom_range(1, 10);
      repeat (n) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            text_q.push_back(8'($urandom_range(0, 1) ? $urandom_range("a", "z")
                                                     : $urandom_range("0", "9")));
         end else if (kind < 40) begin
            text_q.push_back(8'($urandom_range("A", "Z")));
         end else if (kind < 55) begin
            text_q.push_back($urandom_range(0, 1) ? slug_pkg::LEAD_C3 : slug_pkg::LEAD_C2);
            text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
         end else if (kind < 58) begin
            text_q.push_back($urandom_range(0, 1) ? slug_pkg::LEAD_C3 : slug_pkg::LEAD_C2);
         end else if (kind < 68) begin
            text_q.push_back(8'($urandom_range(8'ha0, 8'hff)));
         end else if (kind < 88) begin
            text_q.push_back(8'($urandom_range(8'h20, 8'h2f)));
         end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   task automatic run_text(input int target);
      int sent;
      sent = 0;
      while (sent < target) begin
         make_text();
         foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
         sent += text_q.size();
      end
   endtask

   initial begin : main
      logic [8:0] directed[25];
      directed = '{
         {1'b0, 8'h00}, {1'b0, "A"}, {1'b0, "z"}, {1'b0, 8'hff}, {1'b0, " "},
         {1'b0, 8'hc3}, {1'b0, 8'h9f}, {1'b0, ","}, {1'b0, 8'hc2}, {1'b0, 8'hb5},
         {1'b0, "0"}, {1'b0, "9"}, {1'b0, "Z"}, {1'b0, 8'hc3}, {1'b0, "A"},
         {1'b0, 8'hdf}, {1'b0, 8'hc4}, {1'b0, 8'h80}, {1'b1, "!"},
         {1'b1, 8'hc3},
         {1'b1, "!"},
         {1'b0, 8'hc2}, {1'b1, 8'h7f},
         {1'b0, "-"}, {1'b1, "a"}
      };
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed strings with the hyphen left from reset
      foreach (directed[i]) send_word(directed[i][7:0], directed[i][8]);

      // underscore, with the receiver held off so the input backs up
      write_sep("_");
      hold_rsp = 1'b1;
      run_text(PHASE_WORDS);

      write_sep(8'h00);
      run_text(PHASE_WORDS);

      write_sep(8'hff);
      run_text(PHASE_WORDS);

      // letter as separator, no idling on either side
      write_sep("x");
      steady = 1'b1;
      run_text(PHASE_WORDS);
      steady = 1'b0;

      write_sep(8'($urandom_range(0, 255)));
      run_text(PHASE_WORDS);

      drain();
      if (sb.want_q.size() != 0) begin
         $error("%0d expected output words never arrived", sb.want_q.size());
         sb.errors++;
      end
      $display("Run covered %0d input bytes in %0d strings, giving %0d output words,",
               sb.words_in, sb.text_count, sb.words_out);
      $display("under %0d separator settings including a long receiver hold-off.",
               sep_settings);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/slug_pkg.sv
sv/slug_front.sv
sv/slug_queue.sv
sv/slug_back.sv
sv/slug_transliterator_core.sv
tb/sv/slug_transliterator_core_tb.sv
